/* src/dga_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package dga_pkg;

  localparam int ARG_W   = 32;
  localparam int PSI_W   = 48;
  localparam int NUM_W   = 49;
  localparam int LN_W    = 37;
  localparam int LANES   = 6;
  localparam int DIV_LAT = NUM_W;
  localparam int LOG_LAT = 35;

  localparam logic [15:0] SIX_INT  = 16'd6;
  localparam logic [39:0] LN2_Q40  = 40'hB17217F7D2;
  localparam logic [31:0] LN2_Q32  = 32'hB17217F8;

  localparam logic [19:0] K_T1   = 20'd360360;
  localparam logic [19:0] K_T2   = 20'd60060;
  localparam logic [19:0] K_T4   = 20'd6006;
  localparam logic [19:0] K_T6   = 20'd2860;
  localparam logic [19:0] K_T8   = 20'd3003;
  localparam logic [19:0] K_T10  = 20'd5460;
  localparam logic [19:0] K_T12  = 20'd15202;
  localparam logic [19:0] K_T14  = 20'd60060;
  localparam logic [31:0] K_DEN  = 32'd720720;
  localparam logic [19:0] K_HALF = 20'd360360;

  // ceil(2^60 / 45045); 720720 = 16 * 45045
  localparam logic [44:0] K_RCP  = 45'd25594882997156;

  localparam logic [PSI_W-1:0] PSI_POLE = {1'b1, {(PSI_W-1){1'b0}}};

endpackage
`default_nettype wire

/* src/dga_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module dga_div (
  input  logic                      clk,
  input  logic [dga_pkg::NUM_W-1:0] num,
  input  logic [31:0]               den,
  output logic [dga_pkg::NUM_W-1:0] quo
);

  localparam int N = dga_pkg::NUM_W;

  logic [31:0] rem_r [N];
  logic [N-1:0] num_r [N];
  logic [31:0] den_r [N];
  logic [N-1:0] quo_r [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [31:0]  rem_in;
    logic [N-1:0] num_in;
    logic [31:0]  den_in;
    logic [N-1:0] quo_in;
    logic [32:0]  trial;
    logic         ge;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign num_in = num_r[i-1];
      assign den_in = den_r[i-1];
      assign quo_in = quo_r[i-1];
    end

    assign trial = {rem_in, num_in[N-1-i]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      rem_r[i] <= ge ? 32'(trial - {1'b0, den_in}) : trial[31:0];
      num_r[i] <= num_in;
      den_r[i] <= den_in;
      quo_r[i] <= quo_in | (N'(ge) << (N-1-i));
    end
  end

  assign quo = quo_r[N-1];

endmodule
`default_nettype wire

/* src/dga_log.sv */
`timescale 1ns / 1ps
`default_nettype none
module dga_log (
  input  logic                     clk,
  input  logic [dga_pkg::ARG_W-1:0] arg,
  output logic [dga_pkg::LN_W-1:0]  ln
);

  localparam int R = 32;
  localparam int LN_W_L = dga_pkg::LN_W;

  logic [4:0]  msb;
  logic [31:0] nm_r;
  logic [3:0]  ip_r;
  logic [31:0] m_r [R];
  logic [31:0] f_r [R];
  logic [3:0]  ipd_r [R];
  logic [63:0] p_r;
  logic [43:0] ipm_r;
  logic [44:0] lsum;
  logic [LN_W_L-1:0] ln_r;

  always_comb begin
    msb = '0;
    for (int i = 0; i < 32; i++) begin
      if (arg[i]) msb = 5'(i);
    end
  end

  always_ff @(posedge clk) begin
    nm_r <= arg << (5'd31 - msb);
    ip_r <= 4'(msb - 5'd16);
  end

  for (genvar i = 0; i < R; i++) begin : g_sq
    logic [31:0] m_in;
    logic [31:0] f_in;
    logic [3:0]  ip_in;
    logic [63:0] sq;
    logic [32:0] sh;

    if (i == 0) begin : g_first
      assign m_in  = nm_r;
      assign f_in  = '0;
      assign ip_in = ip_r;
    end else begin : g_next
      assign m_in  = m_r[i-1];
      assign f_in  = f_r[i-1];
      assign ip_in = ipd_r[i-1];
    end

    assign sq = 64'(m_in) * 64'(m_in);
    assign sh = sq[63:31];

    always_ff @(posedge clk) begin
      m_r[i]   <= sh[32] ? sh[32:1] : sh[31:0];
      f_r[i]   <= {f_in[30:0], sh[32]};
      ipd_r[i] <= ip_in;
    end
  end

  assign lsum = 45'(ipm_r) + 45'(p_r[63:24]) + 45'd128;

  always_ff @(posedge clk) begin
    p_r   <= 64'(f_r[R-1]) * 64'(dga_pkg::LN2_Q32);
    ipm_r <= 44'(ipd_r[R-1]) * 44'(dga_pkg::LN2_Q40);
    ln_r  <= lsum[44:8];
  end

  assign ln = ln_r;

endmodule
`default_nettype wire

/* src/digamma_approximation.sv */
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one item per cycle; busy stays low, the receiver cannot stall.
// Depth is set by the 49-stage restoring dividers for the reciprocals, then the
// power chain and a reciprocal multiply that, after the shift by 4, divides by 720720.
// Reset: synchronous, active low; clears all valid bits, no result is in flight.
module digamma_approximation (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [dga_pkg::ARG_W-1:0]  in_arg_value,
  output logic                       out_valid,
  output logic signed [dga_pkg::PSI_W-1:0] out_psi_value,
  output logic                       out_pole_flag
);

  localparam int NW    = dga_pkg::NUM_W;
  localparam int NL    = dga_pkg::LANES;
  localparam int C_Q   = 1 + dga_pkg::DIV_LAT;
  localparam int C_EX  = C_Q + 2;
  localparam int C_PW  = C_Q + 7;
  localparam int C_DV  = C_PW + 4;
  localparam int C_SQ  = C_DV + 3;
  localparam int C_TOT = C_SQ + 1;
  localparam int C_LN  = 1 + dga_pkg::LOG_LAT;
  localparam int D_CT  = C_TOT - 1;
  localparam int D_EN  = C_Q - 1;
  localparam int D_LN  = C_SQ - C_LN;
  localparam int D_EX  = C_SQ - C_EX;
  localparam int D_SG  = C_SQ - C_DV;

  localparam logic [21:0] RCP_HI = dga_pkg::K_RCP[44:23];
  localparam logic [22:0] RCP_LO = dga_pkg::K_RCP[22:0];

  logic        accept;
  logic [15:0] ip16;
  logic        small_arg;
  logic [2:0]  k;

  logic        s1_valid_r;
  logic        s1_pole_r;
  logic [31:0] s1_den_r [NL];
  logic [NL-1:0] s1_en_r;
  logic [31:0] s1_afin_r;

  logic [NW-1:0] lane_q [NL];
  logic [NW-1:0] t_q;
  logic [dga_pkg::LN_W-1:0] ln_q;

  logic          ct_v_r [D_CT];
  logic          ct_p_r [D_CT];
  logic [NL-1:0] en_r [D_EN];

  logic [NW:0]   pair_r [3];
  logic [51:0]   extra_r;
  logic [51:0]   exd_r [D_EX];
  logic [dga_pkg::LN_W-1:0] lnd_r [D_LN];

  logic [31:0]   pw_r [1:7][0:7];
  logic [51:0]   cp_r [8];
  logic [51:0]   pos_r, nega_r, negb_r;
  logic [51:0]   pos2_r, neg2_r;
  logic [43:0]   dv_r;
  logic [43:0]   pp_hh_r;
  logic [44:0]   pp_hl_r;
  logic [43:0]   pp_lh_r;
  logic [44:0]   pp_ll_r;
  logic [88:0]   acc_a_r;
  logic [68:0]   acc_b_r;
  logic [88:0]   acc_sum;
  logic [28:0]   sq_r;
  logic          sg_r;
  logic          sgd_r [D_SG];

  logic signed [55:0] ser;
  logic signed [55:0] tot_r;
  logic signed [55:0] rsum;

  logic                       out_valid_r;
  logic [dga_pkg::PSI_W-1:0]  out_psi_r;
  logic                       out_pole_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign ip16      = in_arg_value[31:16];
  assign small_arg = ip16 < dga_pkg::SIX_INT;
  assign k         = small_arg ? 3'(3'd6 - ip16[2:0]) : 3'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
    s1_pole_r <= in_arg_value == '0;
    s1_afin_r <= {16'(ip16 + 16'(k)), in_arg_value[15:0]};
    for (int j = 0; j < NL; j++) begin
      s1_den_r[j] <= in_arg_value + (32'(j) << 16);
      s1_en_r[j]  <= 3'(j) < k;
    end
  end

  for (genvar j = 0; j < NL; j++) begin : g_lane
    dga_div u_rcp (
      .clk (clk),
      .num ({1'b1, 17'd0, s1_den_r[j][31:1]}),
      .den (s1_den_r[j]),
      .quo (lane_q[j])
    );
  end

  dga_div u_rct (
    .clk (clk),
    .num ({1'b1, 17'd0, s1_afin_r[31:1]}),
    .den (s1_afin_r),
    .quo (t_q)
  );

  dga_log u_log (
    .clk (clk),
    .arg (s1_afin_r),
    .ln  (ln_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < D_CT; i++) ct_v_r[i] <= 1'b0;
    end else begin
      ct_v_r[0] <= s1_valid_r;
      for (int i = 1; i < D_CT; i++) ct_v_r[i] <= ct_v_r[i-1];
    end
    ct_p_r[0] <= s1_pole_r;
    for (int i = 1; i < D_CT; i++) ct_p_r[i] <= ct_p_r[i-1];
    en_r[0] <= s1_en_r;
    for (int i = 1; i < D_EN; i++) en_r[i] <= en_r[i-1];
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < 3; p++) begin
      pair_r[p] <= (NW+1)'(lane_q[2*p] & {NW{en_r[D_EN-1][2*p]}})
                 + (NW+1)'(lane_q[2*p+1] & {NW{en_r[D_EN-1][2*p+1]}});
    end
    extra_r <= 52'(pair_r[0]) + 52'(pair_r[1]) + 52'(pair_r[2]);
    exd_r[0] <= extra_r;
    for (int i = 1; i < D_EX; i++) exd_r[i] <= exd_r[i-1];
    lnd_r[0] <= ln_q;
    for (int i = 1; i < D_LN; i++) lnd_r[i] <= lnd_r[i-1];
  end

  for (genvar s = 1; s <= 7; s++) begin : g_pow
    logic [31:0] lft;
    logic [31:0] rgt;
    logic [63:0] prod;

    if (s == 1) begin : g_first
      assign lft = t_q[31:0];
      assign rgt = t_q[31:0];
    end else begin : g_next
      assign lft = pw_r[s-1][s-1];
      assign rgt = pw_r[s-1][1];
    end

    assign prod = 64'(lft) * 64'(rgt);

    always_ff @(posedge clk) begin
      for (int j = 0; j < 8; j++) begin
        if (j == s) begin
          pw_r[s][j] <= prod[63:32];
        end else if (s == 1) begin
          pw_r[s][j] <= (j == 0) ? t_q[31:0] : 32'd0;
        end else begin
          pw_r[s][j] <= pw_r[s-1][j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cp_r[0] <= 52'(dga_pkg::K_T1)  * 52'(pw_r[7][0]);
    cp_r[1] <= 52'(dga_pkg::K_T2)  * 52'(pw_r[7][1]);
    cp_r[2] <= 52'(dga_pkg::K_T4)  * 52'(pw_r[7][2]);
    cp_r[3] <= 52'(dga_pkg::K_T6)  * 52'(pw_r[7][3]);
    cp_r[4] <= 52'(dga_pkg::K_T8)  * 52'(pw_r[7][4]);
    cp_r[5] <= 52'(dga_pkg::K_T10) * 52'(pw_r[7][5]);
    cp_r[6] <= 52'(dga_pkg::K_T12) * 52'(pw_r[7][6]);
    cp_r[7] <= 52'(dga_pkg::K_T14) * 52'(pw_r[7][7]);
    pos_r   <= cp_r[2] + cp_r[4] + cp_r[6];
    nega_r  <= cp_r[0] + cp_r[1] + cp_r[3];
    negb_r  <= cp_r[5] + cp_r[7];
    pos2_r  <= pos_r;
    neg2_r  <= nega_r + negb_r;
    sg_r    <= neg2_r >= pos2_r;
    // divide by 16 here, the multiply below divides by 45045
    dv_r    <= (neg2_r >= pos2_r)
             ? 44'((neg2_r - pos2_r + 52'(dga_pkg::K_HALF)) >> 4)
             : 44'((pos2_r - neg2_r + 52'(dga_pkg::K_HALF)) >> 4);
    sgd_r[0] <= sg_r;
    for (int i = 1; i < D_SG; i++) sgd_r[i] <= sgd_r[i-1];
  end

  assign acc_sum = acc_a_r + 89'(acc_b_r);

  always_ff @(posedge clk) begin
    pp_hh_r <= 44'(dv_r[43:22]) * 44'(RCP_HI);
    pp_hl_r <= 45'(dv_r[43:22]) * 45'(RCP_LO);
    pp_lh_r <= 44'(dv_r[21:0])  * 44'(RCP_HI);
    pp_ll_r <= 45'(dv_r[21:0])  * 45'(RCP_LO);
    acc_a_r <= {pp_hh_r, pp_ll_r};
    acc_b_r <= 69'({pp_hl_r, 22'd0}) + 69'({pp_lh_r, 23'd0});
    sq_r    <= acc_sum[88:60];
  end

  assign ser  = sgd_r[D_SG-1] ? -$signed(56'(sq_r)) : $signed(56'(sq_r));
  assign rsum = tot_r + 56'sd128;

  always_ff @(posedge clk) begin
    tot_r <= $signed(56'(lnd_r[D_LN-1])) + ser - $signed(56'(exd_r[D_EX-1]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ct_v_r[D_CT-1];
    end
    out_pole_r <= ct_p_r[D_CT-1];
    out_psi_r  <= ct_p_r[D_CT-1] ? dga_pkg::PSI_POLE : rsum[55:8];
  end

  assign out_valid     = out_valid_r;
  assign out_psi_value = $signed(out_psi_r);
  assign out_pole_flag = out_pole_r;

endmodule
`default_nettype wire

/* test/digamma_approximation_tb.sv */
`timescale 1ns / 1ps
module digamma_approximation_tb;

  typedef longint unsigned u64_t;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [dga_pkg::ARG_W-1:0] in_arg_value;
  logic             out_valid;
  logic signed [dga_pkg::PSI_W-1:0] out_psi_value;
  logic             out_pole_flag;
  int               errors;

  digamma_approximation dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_arg_value(in_arg_value), .out_valid(out_valid),
    .out_psi_value(out_psi_value), .out_pole_flag(out_pole_flag)
  );

  function automatic u64_t recip_q32(u64_t a);
    if (a == 0) return 0;
    return ((u64_t'(1) << 48) + (a >> 1)) / a;
  endfunction

  function automatic u64_t ln_q32(u64_t a);
    int   msb;
    u64_t tmp, m, frac, lnq40;
    msb = 0;
    tmp = a;
    frac = 0;
    while (tmp > 1) begin
      tmp >>= 1;
      msb++;
    end
    if (msb < 16 || msb > 31) return 0;
    m = a << (31 - msb);
    for (int i = 0; i < 32; i++) begin
      m = (m * m) >> 31;
      frac <<= 1;
      if (m >= (u64_t'(1) << 32)) begin
        frac |= 1;
        m >>= 1;
      end
    end
    lnq40 = u64_t'(msb - 16) * u64_t'(dga_pkg::LN2_Q40)
          + ((frac * u64_t'(dga_pkg::LN2_Q32)) >> 24);
    return (lnq40 + 128) >> 8;
  endfunction

  function automatic longint series_q32(u64_t a);
    u64_t t[8];
    u64_t pos, neg;
    t[0] = recip_q32(a);
    t[1] = (t[0] * t[0]) >> 32;
    for (int k = 2; k < 8; k++) t[k] = (t[k-1] * t[1]) >> 32;
    pos = u64_t'(dga_pkg::K_T4) * t[2] + u64_t'(dga_pkg::K_T8) * t[4]
        + u64_t'(dga_pkg::K_T12) * t[6];
    neg = u64_t'(dga_pkg::K_T1) * t[0] + u64_t'(dga_pkg::K_T2) * t[1]
        + u64_t'(dga_pkg::K_T6) * t[3] + u64_t'(dga_pkg::K_T10) * t[5]
        + u64_t'(dga_pkg::K_T14) * t[7];
    if (neg >= pos)
      return -longint'((neg - pos + dga_pkg::K_HALF) / dga_pkg::K_DEN);
    return longint'((pos - neg + dga_pkg::K_HALF) / dga_pkg::K_DEN);
  endfunction

  function automatic void digamma_of(input logic [dga_pkg::ARG_W-1:0] arg,
                                     output logic [dga_pkg::PSI_W-1:0] psi,
                                     output logic pole);
    u64_t   a, shift_sum;
    longint total, r;
    a = arg;
    shift_sum = 0;
    pole = 1'b0;
    if (a == 0) begin
      psi = dga_pkg::PSI_POLE;
      pole = 1'b1;
      return;
    end
    while (a < (u64_t'(dga_pkg::SIX_INT) << 16)) begin
      shift_sum += recip_q32(a);
      a += 65536;
    end
    total = longint'(ln_q32(a)) + series_q32(a) - longint'(shift_sum);
    r = longint'((u64_t'(total + (longint'(1) << 56)) + 128) >> 8) - (longint'(1) << 48);
    if (r > 64'sd140737488355327) r = 64'sd140737488355327;
    if (r < -64'sd140737488355328) r = -64'sd140737488355328;
    psi = r[dga_pkg::PSI_W-1:0];
  endfunction

  class digamma_scoreboard;
    logic [dga_pkg::PSI_W-1:0] psi_q[$];
    logic                      pole_q[$];
    logic [dga_pkg::ARG_W-1:0] arg_q[$];

    function void note_arg(logic [dga_pkg::ARG_W-1:0] arg);
      logic [dga_pkg::PSI_W-1:0] p;
      logic f;
      digamma_of(arg, p, f);
      psi_q.push_back(p);
      pole_q.push_back(f);
      arg_q.push_back(arg);
    endfunction

    function string check_result(logic [dga_pkg::PSI_W-1:0] psi, logic pole);
      logic [dga_pkg::PSI_W-1:0] ep;
      logic ef;
      logic [dga_pkg::ARG_W-1:0] ea;
      if (psi_q.size() == 0) return "result with nothing pending";
      ep = psi_q.pop_front();
      ef = pole_q.pop_front();
      ea = arg_q.pop_front();
      if (psi !== ep || pole !== ef)
        return $sformatf("arg %h: psi %h pole %b, want psi %h pole %b",
                         ea, psi, pole, ep, ef);
      return "";
    endfunction
  endclass

  digamma_scoreboard sb;

  task automatic report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    string msg;
    if (rst_n) begin
      if (start && !busy) sb.note_arg(in_arg_value);
      if (out_valid) begin
        msg = sb.check_result(out_psi_value, out_pole_flag);
        if (msg != "") report(msg);
      end
    end
  end

  task automatic send_arg(logic [dga_pkg::ARG_W-1:0] arg, int gap);
    start <= 1'b1;
    in_arg_value <= arg;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      in_arg_value <= $urandom;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic int pick_gap(bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [dga_pkg::ARG_W-1:0] pick_arg();
    case ($urandom_range(0, 5))
      0: return $urandom_range(1, 6 * 65536);
      1: return $urandom_range(1, 1024);
      2: return $urandom_range(6 * 65536 - 64, 6 * 65536 + 64);
      3: return 32'hFFFFFFFF - $urandom_range(0, 4096);
      4: return ($urandom_range(0, 19) == 0) ? '0 : $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [dga_pkg::ARG_W-1:0] directed[$];
    int limit;
    bit burst;
    sb = new();
    errors = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_arg_value = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed = '{32'h0, 32'h1, 32'h2, 32'h8000, 32'h10000, 32'h18000, 32'h20000,
                 32'h5FFFF, 32'h60000, 32'h60001, 32'h0, 32'h70000, 32'hFFFF,
                 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA,
                 32'h5555_5555, 32'h0001_0001, 32'hFFFF_0000};
    foreach (directed[i]) send_arg(directed[i], pick_gap(i < 10));
    for (int n = 0; n < 800; n++) begin
      burst = (n % 100) < 20;
      send_arg(pick_arg(), pick_gap(burst));
    end
    start <= 1'b0;
    limit = 0;
    while (sb.psi_q.size() != 0 && limit < 1000) begin
      @(posedge clk);
      limit++;
    end
    repeat (120) @(posedge clk);
    if (sb.psi_q.size() != 0) report("results still pending at end");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* files.f */
src/dga_pkg.sv
src/dga_div.sv
src/dga_log.sv
src/digamma_approximation.sv
test/digamma_approximation_tb.sv
